FILE: rtl/core/round_robin_task_dispatcher_top_macros.svh
// ----------------------------------------------------------------------------
// Round-robin task dispatcher assertion macros
// Concurrent assertion shorthands clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_DISPATCHER_TOP_MACROS_SVH
`define ROUND_ROBIN_TASK_DISPATCHER_TOP_MACROS_SVH

// same-cycle implication
`define RRTD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rrtd_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher package
// Field widths, command, kind and status codes, micro-ops and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtd_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int ID_W       = 4;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_REQ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_LOCK = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNLOCK   = 3'd6;

    localparam logic [KIND_W-1:0] KIND_FOREVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONCE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_TASKS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_REQUEST   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TASK      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    localparam int UOP_W = 4;

    localparam logic [UOP_W-1:0] UOP_NONE      = 4'd0;
    localparam logic [UOP_W-1:0] UOP_LOAD      = 4'd1;
    localparam logic [UOP_W-1:0] UOP_ADD_FAIL  = 4'd2;
    localparam logic [UOP_W-1:0] UOP_FAIL_OUT  = 4'd3;
    localparam logic [UOP_W-1:0] UOP_SCAN_STEP = 4'd4;
    localparam logic [UOP_W-1:0] UOP_ALLOC     = 4'd5;
    localparam logic [UOP_W-1:0] UOP_ORDER_RD  = 4'd6;
    localparam logic [UOP_W-1:0] UOP_KIND_RD   = 4'd7;
    localparam logic [UOP_W-1:0] UOP_EVAL      = 4'd8;
    localparam logic [UOP_W-1:0] UOP_SHIFT_RD  = 4'd9;
    localparam logic [UOP_W-1:0] UOP_SHIFT_WR  = 4'd10;
    localparam logic [UOP_W-1:0] UOP_DELETE    = 4'd11;
    localparam logic [UOP_W-1:0] UOP_MISC      = 4'd12;

    typedef struct packed {
        logic [UOP_W-1:0] uop;
        logic             out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             add_ok;
        logic             cur_ok;
        logic             scan_free;
        logic             need_delete;
        logic             shift_more;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/rrtd_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher controller
// Sequences one command at a time through decode, slot scan, table reads,
// entry shifting and result hand-off; drives the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtd_ctrl import rrtd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t stat,
    output ctrl_cmd_t       ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_KIND_RD  = 3'd3;
    localparam logic [2:0] S_EVAL     = 3'd4;
    localparam logic [2:0] S_SHIFT    = 3'd5;
    localparam logic [2:0] S_SHIFT_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        ctl.uop      = UOP_NONE;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.uop    = UOP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (stat.cmd == CMD_ADD) begin
                    if (stat.add_ok) begin
                        state_next = S_SCAN;
                    end else begin
                        ctl.uop    = UOP_ADD_FAIL;
                        state_next = S_DONE;
                    end
                end else if (stat.cmd == CMD_START || stat.cmd == CMD_DISPATCH ||
                             stat.cmd == CMD_FINISH) begin
                    if (stat.cur_ok) begin
                        ctl.uop    = UOP_ORDER_RD;
                        state_next = S_KIND_RD;
                    end else begin
                        ctl.uop    = UOP_FAIL_OUT;
                        state_next = S_DONE;
                    end
                end else begin
                    ctl.uop    = UOP_MISC;
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                if (stat.scan_free) begin
                    ctl.uop    = UOP_ALLOC;
                    state_next = S_DONE;
                end else begin
                    ctl.uop = UOP_SCAN_STEP;
                end
            end
            S_KIND_RD: begin
                ctl.uop    = UOP_KIND_RD;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                ctl.uop    = UOP_EVAL;
                state_next = stat.need_delete ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                if (stat.shift_more) begin
                    ctl.uop    = UOP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end else begin
                    ctl.uop    = UOP_DELETE;
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                ctl.uop    = UOP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rrtd_datapath.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher datapath
// Holds the run-order and kind memories, slot flags, count, cursor and the
// result registers; carries out one micro-op per cycle for the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtd_datapath import rrtd_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [CMD_W-1:0]      in_cmd,
    input  wire logic [KIND_W-1:0]     in_task_type,
    input  wire logic [ID_W-1:0]       in_task_id,
    input  wire ctrl_cmd_t             ctl,
    output dp_status_t                 stat,
    output logic [STATUS_W-1:0]        out_status,
    output logic [SLOT_OUT_W-1:0]      out_slot,
    output logic                       out_run
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [CMD_W-1:0]      cmd_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [ID_W-1:0]       id_reg;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [SW-1:0]         cursor_reg;
    logic [SW-1:0]         cursor_next;
    logic                  hr_reg;
    logic                  hr_next;
    logic [MAX_TASKS-1:0]  used_reg;
    logic [MAX_TASKS-1:0]  used_next;
    logic [MAX_TASKS-1:0]  req_reg;
    logic [MAX_TASKS-1:0]  req_next;
    logic [MAX_TASKS-1:0]  lock_reg;
    logic [MAX_TASKS-1:0]  lock_next;

    logic [SW-1:0]         scan_reg;
    logic [SW-1:0]         shift_reg;
    logic [SW-1:0]         slot_reg;

    logic [SW-1:0]         order_mem [MAX_TASKS];
    logic [KIND_W-1:0]     kind_mem  [MAX_TASKS];
    logic [SW-1:0]         order_rdata_reg;
    logic [KIND_W-1:0]     kind_rdata_reg;

    logic [STATUS_W-1:0]   res_status_reg;
    logic [STATUS_W-1:0]   res_status_next;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [SLOT_OUT_W-1:0] res_slot_next;
    logic                  res_run_reg;
    logic                  res_run_next;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic                  out_run_reg;

    logic [SW-1:0]         id_idx;
    logic                  id_ok;
    logic [CW-1:0]         shift_inc;
    logic [CW-1:0]         cursor_inc;
    logic [CW-1:0]         count_dec;
    logic                  order_we;
    logic [SW-1:0]         order_waddr;
    logic [SW-1:0]         order_wdata;
    logic                  order_re;
    logic [SW-1:0]         order_raddr;
    logic                  is_req_kind;

    assign id_idx      = SW'(id_reg);
    assign id_ok       = (int'(id_reg) < MAX_TASKS) && used_reg[id_idx];
    assign shift_inc   = CW'(shift_reg) + CW'(1);
    assign cursor_inc  = CW'(cursor_reg) + CW'(1);
    assign count_dec   = count_reg - CW'(1);
    assign is_req_kind = (kind_rdata_reg == KIND_REQUEST);

    assign stat.cmd         = cmd_reg;
    assign stat.add_ok      = (kind_reg <= KIND_REQUEST) && (count_reg < CW'(MAX_TASKS));
    assign stat.cur_ok      = (cmd_reg == CMD_START) ? (count_reg != '0)
                                                     : (CW'(cursor_reg) < count_reg);
    assign stat.scan_free   = !used_reg[scan_reg];
    assign stat.need_delete = (cmd_reg == CMD_FINISH) && !lock_reg[slot_reg] &&
                              (kind_rdata_reg == KIND_ONCE);
    assign stat.shift_more  = shift_inc < count_reg;

    assign order_we    = (ctl.uop == UOP_ALLOC) || (ctl.uop == UOP_SHIFT_WR);
    assign order_waddr = (ctl.uop == UOP_ALLOC) ? SW'(count_reg) : shift_reg;
    assign order_wdata = (ctl.uop == UOP_ALLOC) ? scan_reg : order_rdata_reg;
    assign order_re    = (ctl.uop == UOP_ORDER_RD) || (ctl.uop == UOP_SHIFT_RD);
    assign order_raddr = (ctl.uop == UOP_SHIFT_RD) ? SW'(shift_inc) :
                         (cmd_reg == CMD_START)    ? '0 : cursor_reg;

    always_comb begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        hr_next         = hr_reg;
        used_next       = used_reg;
        req_next        = req_reg;
        lock_next       = lock_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_run_next    = res_run_reg;
        unique case (ctl.uop)
            UOP_NONE, UOP_LOAD, UOP_SCAN_STEP, UOP_KIND_RD,
            UOP_SHIFT_RD, UOP_SHIFT_WR: begin
            end
            UOP_ADD_FAIL: begin
                res_status_next = (kind_reg > KIND_REQUEST) ? ST_NO_TASK : ST_FULL;
                res_slot_next   = '0;
                res_run_next    = 1'b0;
            end
            UOP_FAIL_OUT: begin
                hr_next = 1'b0;
                if (cmd_reg == CMD_START) begin
                    cursor_next = '0;
                end
                res_status_next = ST_OUT_OF_TASKS;
                res_slot_next   = '0;
                res_run_next    = 1'b0;
            end
            UOP_ALLOC: begin
                used_next[scan_reg] = 1'b1;
                req_next[scan_reg]  = 1'b0;
                lock_next[scan_reg] = 1'b0;
                count_next          = count_reg + CW'(1);
                res_status_next     = ST_OK;
                res_slot_next       = SLOT_OUT_W'(scan_reg);
                res_run_next        = 1'b0;
            end
            UOP_ORDER_RD: begin
                if (cmd_reg == CMD_START) begin
                    cursor_next = '0;
                    hr_next     = 1'b0;
                end
            end
            UOP_EVAL: begin
                res_slot_next = SLOT_OUT_W'(slot_reg);
                priority if (cmd_reg == CMD_START) begin
                    if (kind_rdata_reg == KIND_FOREVER || kind_rdata_reg == KIND_ONCE) begin
                        res_status_next = ST_OK;
                        res_run_next    = 1'b1;
                    end else begin
                        res_status_next = ST_OUT_OF_TASKS;
                        res_slot_next   = '0;
                        res_run_next    = 1'b0;
                    end
                end else if (cmd_reg == CMD_DISPATCH) begin
                    if (is_req_kind && !req_reg[slot_reg]) begin
                        hr_next         = 1'b0;
                        res_status_next = ST_NO_REQUEST;
                        res_run_next    = 1'b0;
                    end else begin
                        hr_next         = 1'b1;
                        res_status_next = ST_OK;
                        res_run_next    = 1'b1;
                    end
                end else begin
                    if (is_req_kind && hr_reg) begin
                        req_next[slot_reg] = 1'b0;
                    end
                    hr_next         = 1'b0;
                    res_status_next = ST_OK;
                    res_run_next    = 1'b0;
                    if (!lock_reg[slot_reg] && kind_rdata_reg != KIND_ONCE) begin
                        cursor_next = (cursor_inc >= count_reg) ? '0 : SW'(cursor_inc);
                    end
                end
            end
            UOP_DELETE: begin
                count_next          = count_dec;
                used_next[slot_reg] = 1'b0;
                req_next[slot_reg]  = 1'b0;
                lock_next[slot_reg] = 1'b0;
                if (CW'(cursor_reg) >= count_dec) begin
                    cursor_next = '0;
                end
            end
            UOP_MISC: begin
                res_run_next = 1'b0;
                if (cmd_reg == CMD_SET_REQ || cmd_reg == CMD_SET_LOCK ||
                    cmd_reg == CMD_UNLOCK) begin
                    if (id_ok) begin
                        if (cmd_reg == CMD_SET_REQ) begin
                            req_next[id_idx] = 1'b1;
                        end else begin
                            lock_next[id_idx] = (cmd_reg == CMD_SET_LOCK);
                        end
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_OUT_W'(id_reg);
                    end else begin
                        res_status_next = ST_NO_TASK;
                        res_slot_next   = '0;
                    end
                end else begin
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cursor_reg <= '0;
            hr_reg     <= 1'b0;
            used_reg   <= '0;
            req_reg    <= '0;
            lock_reg   <= '0;
        end else begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            hr_reg     <= hr_next;
            used_reg   <= used_next;
            req_reg    <= req_next;
            lock_reg   <= lock_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_run_reg    <= res_run_next;
        if (ctl.uop == UOP_LOAD) begin
            cmd_reg  <= in_cmd;
            kind_reg <= in_task_type;
            id_reg   <= in_task_id;
            scan_reg <= '0;
        end else if (ctl.uop == UOP_SCAN_STEP) begin
            scan_reg <= scan_reg + SW'(1);
        end
        if (ctl.uop == UOP_KIND_RD) begin
            slot_reg <= order_rdata_reg;
        end
        if (ctl.uop == UOP_EVAL) begin
            shift_reg <= cursor_reg;
        end else if (ctl.uop == UOP_SHIFT_WR) begin
            shift_reg <= shift_reg + SW'(1);
        end
        if (ctl.out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_run_reg    <= res_run_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_waddr] <= order_wdata;
        end
        if (order_re) begin
            order_rdata_reg <= order_mem[order_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.uop == UOP_ALLOC) begin
            kind_mem[scan_reg] <= kind_reg;
        end
        if (ctl.uop == UOP_KIND_RD) begin
            kind_rdata_reg <= kind_mem[order_rdata_reg];
        end
    end

    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_run    = out_run_reg;

endmodule

`default_nettype wire

FILE: rtl/core/round_robin_task_dispatcher_top.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher
// Command channel s_* in, one result beat m_* out for every command beat.
// Commands: add, start, dispatch, finish, set_request, set_lock, unlock.
// One command is in flight at a time; s_ready is high only while idle.
// A result waits in an output register, so the next command beat is taken
// while the receiver holds m_ready low; the following result then waits.
// Steps from an accepted beat to its result:
//   flag commands, unused code, failed commands: straight to the result
//   add: free-slot scan from slot 0 up to the lowest free slot, then allocate
//   start, dispatch, finish without delete: order then kind memory read
//   finish deleting a run-once entry: the entries after it shifted down,
//   one read and one write of the order memory per entry
// m_valid rises as the formed result is loaded into the output register.
// Reset (synchronous) clears the slot flags, task count, cursor and handshake
// state; the order and kind memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_dispatcher_top import rrtd_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CMD_W-1:0]      s_cmd,
    input  wire logic [KIND_W-1:0]     s_task_type,
    input  wire logic [ID_W-1:0]       s_task_id,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [SLOT_OUT_W-1:0]      m_slot_out,
    output logic                       m_run_now
);

    ctrl_cmd_t  ctl;
    dp_status_t stat;

    rrtd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    rrtd_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_cmd       (s_cmd),
        .in_task_type (s_task_type),
        .in_task_id   (s_task_id),
        .ctl          (ctl),
        .stat         (stat),
        .out_status   (m_status),
        .out_slot     (m_slot_out),
        .out_run      (m_run_now)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rrtd_checker.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher checker
// Port-level assertions on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_task_dispatcher_top_macros.svh"

module rrtd_checker import rrtd_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [CMD_W-1:0]      s_cmd,
    input wire logic [KIND_W-1:0]     s_task_type,
    input wire logic [ID_W-1:0]       s_task_id,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [STATUS_W-1:0]   m_status,
    input wire logic [SLOT_OUT_W-1:0] m_slot_out,
    input wire logic                  m_run_now
);

    `RRTD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot_out) && $stable(m_run_now), "result beat changed while stalled")
    `RRTD_ASSERT_SAME(a_run_ok, m_valid && m_run_now, m_status == ST_OK, "run_now with failing status")
    `RRTD_ASSERT_SAME(a_fail_zero, m_valid && (m_status == ST_OUT_OF_TASKS || m_status == ST_NO_TASK || m_status == ST_FULL), m_slot_out == '0 && !m_run_now, "failed command named a slot")
    `RRTD_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "command beat taken while busy")

endmodule

bind round_robin_task_dispatcher_top rrtd_checker u_rrtd_checker (.*);

`default_nettype wire

FILE: bench/round_robin_task_dispatcher_top_test.sv
// ----------------------------------------------------------------------------
// Round-robin task dispatcher testbench
// Drives command beats from a queue of pending items and predicts each result
// from a local copy of the task table as the beat is accepted. Compares every
// result beat field by field, with random idling on both sides, a quiet
// stretch and one long receiver hold-off.
// ----------------------------------------------------------------------------
module round_robin_task_dispatcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrtd_pkg::*;

    localparam int MAX_TASKS   = MAX_TASKS_DEF;
    localparam int ITEMS       = 800;
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
    } sched_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  run;
    } sched_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [KIND_W-1:0]     s_task_type = '0;
    logic [ID_W-1:0]       s_task_id = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_OUT_W-1:0] m_slot_out;
    logic                  m_run_now;

    round_robin_task_dispatcher_top #(
        .MAX_TASKS(MAX_TASKS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_task_type(s_task_type),
        .s_task_id  (s_task_id),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot_out (m_slot_out),
        .m_run_now  (m_run_now)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // local copy of the task table
    logic [ID_W-1:0]   ord_tab  [MAX_TASKS];
    logic              used     [MAX_TASKS];
    logic [KIND_W-1:0] kind_of  [MAX_TASKS];
    logic              req_pend [MAX_TASKS];
    logic              locked   [MAX_TASKS];
    int                n_tasks = 0;
    int                cur_pos = 0;
    logic              served = 1'b0;

    sched_beat_t   pending_q[$];
    sched_result_t result_q[$];
    sched_beat_t   cur_beat;
    bit            beat_taken = 1'b0;
    bit            quiet = 1'b0;
    int            n_queued = 0;
    int            n_taken = 0;
    int            n_errors = 0;
    int            n_cycles = 0;
    int            hold_req = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    initial begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            ord_tab[i]  = '0;
            used[i]     = 1'b0;
            kind_of[i]  = KIND_FOREVER;
            req_pend[i] = 1'b0;
            locked[i]   = 1'b0;
        end
    end

    function automatic sched_result_t sched_step(sched_beat_t b);
        sched_result_t   r;
        logic [ID_W-1:0] sl;
        int              fs;
        int              i;
        r.status = ST_OK;
        r.slot   = '0;
        r.run    = 1'b0;
        case (b.cmd)
            CMD_ADD: begin
                fs = -1;
                for (i = MAX_TASKS - 1; i >= 0; i--)
                    if (!used[i]) fs = i;
                if (b.kind > KIND_REQUEST) begin
                    r.status = ST_NO_TASK;
                end else if (n_tasks >= MAX_TASKS || fs < 0) begin
                    r.status = ST_FULL;
                end else begin
                    used[fs]         = 1'b1;
                    kind_of[fs]      = b.kind;
                    req_pend[fs]     = 1'b0;
                    locked[fs]       = 1'b0;
                    ord_tab[n_tasks] = ID_W'(fs);
                    n_tasks++;
                    r.slot = SLOT_OUT_W'(fs);
                end
            end
            CMD_START: begin
                cur_pos = 0;
                served  = 1'b0;
                if (n_tasks == 0) begin
                    r.status = ST_OUT_OF_TASKS;
                end else begin
                    sl = ord_tab[0];
                    if (kind_of[sl] == KIND_FOREVER || kind_of[sl] == KIND_ONCE) begin
                        r.slot = sl;
                        r.run  = 1'b1;
                    end else begin
                        r.status = ST_OUT_OF_TASKS;
                    end
                end
            end
            CMD_DISPATCH: begin
                served = 1'b0;
                if (n_tasks == 0 || cur_pos >= n_tasks) begin
                    r.status = ST_OUT_OF_TASKS;
                end else begin
                    sl     = ord_tab[cur_pos];
                    r.slot = sl;
                    if (kind_of[sl] == KIND_REQUEST && !req_pend[sl]) begin
                        r.status = ST_NO_REQUEST;
                    end else begin
                        served = 1'b1;
                        r.run  = 1'b1;
                    end
                end
            end
            CMD_FINISH: begin
                if (n_tasks == 0 || cur_pos >= n_tasks) begin
                    served   = 1'b0;
                    r.status = ST_OUT_OF_TASKS;
                end else begin
                    sl     = ord_tab[cur_pos];
                    r.slot = sl;
                    if (kind_of[sl] == KIND_REQUEST && served) req_pend[sl] = 1'b0;
                    served = 1'b0;
                    if (!locked[sl]) begin
                        if (kind_of[sl] == KIND_ONCE) begin
                            for (i = cur_pos; i + 1 < n_tasks; i++)
                                ord_tab[i] = ord_tab[i + 1];
                            n_tasks--;
                            used[sl]     = 1'b0;
                            req_pend[sl] = 1'b0;
                            locked[sl]   = 1'b0;
                            if (cur_pos >= n_tasks) cur_pos = 0;
                        end else begin
                            cur_pos = (cur_pos + 1 >= n_tasks) ? 0 : cur_pos + 1;
                        end
                    end
                end
            end
            CMD_SET_REQ, CMD_SET_LOCK, CMD_UNLOCK: begin
                if (int'(b.id) >= MAX_TASKS || !used[b.id]) begin
                    r.status = ST_NO_TASK;
                end else begin
                    r.slot = b.id;
                    if (b.cmd == CMD_SET_REQ) req_pend[b.id] = 1'b1;
                    else locked[b.id] = (b.cmd == CMD_SET_LOCK);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        n_errors++;
        $display("tb: mismatch at cycle %0d: %s", n_cycles, what);
    endtask

    // input side: predict on every accepted beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            result_q.push_back(sched_step(cur_beat));
            beat_taken = 1'b1;
            n_taken++;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
                cur_beat = pending_q.pop_front();
                s_valid     <= 1'b1;
                s_cmd       <= cur_beat.cmd;
                s_task_type <= cur_beat.kind;
                s_task_id   <= cur_beat.id;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with the long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || $urandom_range(99) >= 10;
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                          m_status));
            end else begin
                want = result_q.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", m_status,
                                              want.status));
                if (m_slot_out !== want.slot)
                    report_mismatch($sformatf("slot_out %0d, expected %0d", m_slot_out,
                                              want.slot));
                if (m_run_now !== want.run)
                    report_mismatch($sformatf("run_now %0b, expected %0b", m_run_now,
                                              want.run));
            end
        end
    end

    initial begin
        while (n_cycles < CYCLE_LIMIT) @(posedge aclk) n_cycles++;
        $display("tb: failure");
        $finish;
    end

    task automatic queue_beat(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] kind,
                              logic [ID_W-1:0] id);
        sched_beat_t b;
        b.cmd  = cmd;
        b.kind = kind;
        b.id   = id;
        pending_q.push_back(b);
        n_queued++;
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        int sticky;
        int i;
        int r;
        sticky = 0;
        for (i = 0; i < MAX_TASKS; i++)
            if (used[i] && kind_of[i] != KIND_ONCE) sticky++;
        r = $urandom_range(99);
        if (r < 5) return KIND_BAD;
        if (sticky >= 8 || r < 70) return KIND_ONCE;
        return (r < 85) ? KIND_FOREVER : KIND_REQUEST;
    endfunction

    function automatic logic [ID_W-1:0] pick_slot(bit want_locked);
        logic [ID_W-1:0] cand[$];
        int              i;
        for (i = 0; i < MAX_TASKS; i++)
            if (used[i] && (!want_locked || locked[i])) cand.push_back(ID_W'(i));
        if (cand.size() == 0 || $urandom_range(99) < 15) return ID_W'($urandom_range(15));
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    task automatic queue_run(int pairs);
        int k;
        if ($urandom_range(99) < 30)
            queue_beat(CMD_START, KIND_W'($urandom_range(3)), ID_W'($urandom_range(15)));
        for (k = 0; k < pairs; k++) begin
            if ($urandom_range(99) < 35)
                queue_beat(CMD_SET_REQ, KIND_W'($urandom_range(3)), pick_slot(1'b0));
            if ($urandom_range(99) < 10)
                queue_beat(CMD_SET_LOCK, KIND_W'($urandom_range(3)), pick_slot(1'b0));
            if ($urandom_range(99) < 30)
                queue_beat(CMD_UNLOCK, KIND_W'($urandom_range(3)), pick_slot(1'b1));
            if ($urandom_range(99) < 90)
                queue_beat(CMD_DISPATCH, KIND_W'($urandom_range(3)),
                           ID_W'($urandom_range(15)));
            queue_beat(CMD_FINISH, KIND_W'($urandom_range(3)), ID_W'($urandom_range(15)));
        end
    endtask

    task automatic wait_drained();
        while (n_taken != n_queued) @(negedge aclk);
    endtask

    initial begin : stimulus
        int chunk;
        int r;
        int k;
        logic [CMD_W-1:0] c;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, unknown slots, bad kind, unused code
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_START, KIND_FOREVER, 4'd0);
        queue_beat(CMD_SET_REQ, KIND_FOREVER, 4'd15);
        queue_beat(CMD_UNLOCK, KIND_FOREVER, 4'd0);
        queue_beat(CMD_ADD, KIND_BAD, 4'd0);
        queue_beat(CMD_UNUSED, KIND_BAD, 4'd15);
        // request head blocks start; walk each kind through dispatch and finish
        queue_beat(CMD_ADD, KIND_REQUEST, 4'd0);
        queue_beat(CMD_START, KIND_FOREVER, 4'd0);
        queue_beat(CMD_ADD, KIND_FOREVER, 4'd0);
        queue_beat(CMD_ADD, KIND_ONCE, 4'd0);
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_SET_REQ, KIND_FOREVER, 4'd0);
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        // locked task holds the cursor
        queue_beat(CMD_SET_LOCK, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_DISPATCH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_UNLOCK, KIND_FOREVER, 4'd0);
        queue_beat(CMD_FINISH, KIND_FOREVER, 4'd0);
        queue_beat(CMD_START, KIND_FOREVER, 4'd0);

        chunk = 0;
        while (n_queued < 25 + ITEMS) begin
            wait_drained();
            quiet = (chunk >= 60 && chunk < 110);
            r = $urandom_range(99);
            if (chunk == 0 || r >= 95) begin
                // fill the table and go one past full
                repeat (MAX_TASKS - n_tasks + 1)
                    queue_beat(CMD_ADD, KIND_ONCE, ID_W'($urandom_range(15)));
            end else if (chunk == 30) begin
                // stall the receiver while beats keep coming
                hold_req++;
                queue_run(8);
            end else if (r < 45) begin
                queue_run($urandom_range(2, 6));
            end else if (r < 65) begin
                repeat ($urandom_range(1, 3))
                    queue_beat(CMD_ADD, pick_kind(), ID_W'($urandom_range(15)));
            end else if (r < 80) begin
                repeat ($urandom_range(3, 6)) begin
                    k = $urandom_range(2);
                    c = (k == 0) ? CMD_SET_REQ : (k == 1) ? CMD_SET_LOCK : CMD_UNLOCK;
                    queue_beat(c, KIND_W'($urandom_range(3)), pick_slot(c == CMD_UNLOCK));
                end
            end else begin
                repeat ($urandom_range(4, 8)) begin
                    c = CMD_W'($urandom_range(7));
                    queue_beat(c, (c == CMD_ADD) ? pick_kind() : KIND_W'($urandom_range(3)),
                               ID_W'($urandom_range(15)));
                end
            end
            chunk++;
        end

        wait_drained();
        while (result_q.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
